// File: sv/chrt_pkg.sv
package chrt_pkg;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_UNUSED = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  localparam logic [14:0] CtrlType = 15'd5004;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] record_number;
    logic [14:0] thing_type;
    logic [15:0] option_flags;
    logic [15:0] tag_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  slot_index;
    logic [14:0] found_type;
    logic [15:0] found_options;
    logic [15:0] found_tag;
  } rsp_t;

endpackage

// File: sv/chrt_front.sv
// Front end: takes request beats, computes the bucket of the key and
// pushes the request and its bucket into a two-entry queue for the back end.
module chrt_front #(
  parameter int unsigned Buckets = 1021,
  parameter int unsigned BW      = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  chrt_pkg::req_t req_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output chrt_pkg::req_t cmd_o,
  output logic [BW-1:0]  cmd_bucket_o
);

  localparam int unsigned KW = 16 + BW;

  // Reciprocal estimate of key / Buckets, then one correcting subtract.
  localparam int unsigned Shift = 16 + BW + 1;
  localparam logic [Shift:0] Recip = (Shift+1)'((64'd1 << Shift) / Buckets);

  logic [1:0]        cnt_q, cnt_d;
  logic              rd_q, rd_d, wr_q, wr_d;
  chrt_pkg::req_t    req_mem_q [2];
  logic [BW-1:0]     bkt_mem_q [2];
  logic [KW+Shift:0] prod;
  logic [15:0]       quot;
  logic [KW-1:0]     rem_w;
  logic [BW-1:0]     bucket;
  logic              push, pop;

  always_comb begin
    prod  = (KW+Shift+1)'(req_i.record_number) * (KW+Shift+1)'(Recip);
    quot  = 16'(prod >> Shift);
    rem_w = KW'(req_i.record_number) - KW'(KW'(quot) * KW'(Buckets));
    if (rem_w >= KW'(Buckets)) begin
      rem_w = rem_w - KW'(Buckets);
    end
    bucket = BW'(rem_w);
  end

  assign req_ready_o  = (cnt_q != 2'd2);
  assign push         = req_valid_i && req_ready_o;
  assign cmd_valid_o  = (cnt_q != 2'd0);
  assign pop          = cmd_valid_o && cmd_ready_i;
  assign cmd_o        = req_mem_q[rd_q];
  assign cmd_bucket_o = bkt_mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    wr_d  = wr_q;
    if (push) begin
      wr_d = ~wr_q;
    end
    if (pop) begin
      rd_d = ~rd_q;
    end
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      req_mem_q[wr_q] <= req_i;
      bkt_mem_q[wr_q] <= bucket;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !push) else $error("push into full queue");
  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o |-> (32'(cmd_bucket_o) < Buckets)) else $error("bucket out of range");

endmodule

// File: sv/chrt_back.sv
// Back end: walks the chain of one command at a time through the bucket
// and slot memories, one memory read per step, and holds the answer beat
// in an output register.
module chrt_back #(
  parameter int unsigned Buckets  = 1021,
  parameter int unsigned Capacity = 1024,
  parameter int unsigned BW       = 10,
  parameter int unsigned SW       = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  chrt_pkg::req_t cmd_i,
  input  logic [BW-1:0]  cmd_bucket_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output chrt_pkg::rsp_t rsp_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLR   = 6'b000010,
    S_HEAD  = 6'b000100,
    S_SLOT  = 6'b001000,
    S_CHECK = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [SW:0]    count_q, count_d;
  logic [BW:0]    clr_q, clr_d;
  logic           boot_q;
  chrt_pkg::req_t cmd_q;
  logic [BW-1:0]  bkt_q;
  logic [SW-1:0]  cur_q, cur_d;
  logic [SW-1:0]  head_q;

  logic           bvalid_mem_q [Buckets];
  logic [SW-1:0]  head_mem_q   [Buckets];
  logic [15:0]    key_mem_q    [Capacity];
  logic [SW:0]    next_mem_q   [Capacity];
  logic [46:0]    pay_mem_q    [Capacity];

  logic           bv_rd_q;
  logic [SW-1:0]  head_rd_q;
  logic [15:0]    key_rd_q;
  logic [SW:0]    next_rd_q;
  logic [46:0]    pay_rd_q;

  logic           rsp_valid_q;
  chrt_pkg::rsp_t rsp_q, rsp_d;
  logic           rsp_load;

  logic           bv_we, bv_wval, head_we, slot_we;
  logic [BW-1:0]  bv_waddr;
  logic [14:0]    ins_type;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign ins_type    = (cmd_q.thing_type == chrt_pkg::CtrlType) ? '0 : cmd_q.thing_type;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    clr_d    = clr_q;
    cur_d    = cur_q;
    rsp_d    = '0;
    rsp_load = 1'b0;
    bv_we    = 1'b0;
    bv_wval  = 1'b0;
    bv_waddr = bkt_q;
    head_we  = 1'b0;
    slot_we  = 1'b0;
    rsp_d.status = chrt_pkg::ST_NOT_FOUND;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          priority case (cmd_i.req_type)
            chrt_pkg::REQ_CLEAR: begin
              clr_d   = '0;
              state_d = S_CLR;
            end
            chrt_pkg::REQ_INSERT, chrt_pkg::REQ_LOOKUP: state_d = S_HEAD;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_CLR: begin
        // One bucket valid bit cleared per cycle; the sweep after reset gives no answer.
        bv_we    = 1'b1;
        bv_waddr = BW'(clr_q);
        clr_d    = clr_q + 1'b1;
        if (32'(clr_q) == Buckets - 1) begin
          count_d = '0;
          state_d = boot_q ? S_IDLE : S_OUT;
        end
      end
      S_HEAD: begin
        cur_d   = head_rd_q;
        state_d = bv_rd_q ? S_SLOT : S_CHECK;
      end
      S_SLOT: state_d = S_CHECK;
      default: begin
        // S_CHECK and S_OUT
        if (state_q == S_CHECK) begin
          if (bv_rd_q && ({1'b0, cur_q} < count_q) && (key_rd_q == cmd_q.record_number)) begin
            if (cmd_q.req_type == chrt_pkg::REQ_INSERT) begin
              rsp_d.status = chrt_pkg::ST_DUPLICATE;
            end else begin
              rsp_d.status        = chrt_pkg::ST_OK;
              rsp_d.slot_index    = 10'(cur_q);
              rsp_d.found_type    = pay_rd_q[14:0];
              rsp_d.found_options = pay_rd_q[30:15];
              rsp_d.found_tag     = pay_rd_q[46:31];
            end
            state_d = S_OUT;
          end else if (bv_rd_q && ({1'b0, cur_q} < count_q) && !next_rd_q[SW]) begin
            cur_d   = next_rd_q[SW-1:0];
            state_d = S_SLOT;
          end else if (cmd_q.req_type == chrt_pkg::REQ_INSERT) begin
            if (32'(count_q) >= Capacity) begin
              rsp_d.status = chrt_pkg::ST_FULL;
            end else begin
              rsp_d.status     = chrt_pkg::ST_OK;
              rsp_d.slot_index = 10'(count_q);
              slot_we          = 1'b1;
              head_we          = 1'b1;
              bv_we            = 1'b1;
              bv_wval          = 1'b1;
              count_d          = count_q + 1'b1;
            end
            state_d = S_OUT;
          end else begin
            state_d = S_OUT;
          end
          rsp_load = (state_d == S_OUT);
        end else if (!rsp_valid_q || rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
    endcase
    if (state_q == S_CLR && state_d == S_OUT) begin
      rsp_load     = 1'b1;
      rsp_d        = '0;
      rsp_d.status = chrt_pkg::ST_OK;
    end
    if (state_q == S_IDLE && state_d == S_OUT) begin
      rsp_load = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      count_q     <= '0;
      clr_q       <= '0;
      boot_q      <= 1'b1;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      clr_q   <= clr_d;
      if (state_q == S_CLR && state_d != S_CLR) begin
        boot_q <= 1'b0;
      end
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (state_q == S_HEAD) begin
      head_q <= head_rd_q;
    end
    if (rsp_load) begin
      rsp_q <= rsp_d;
    end
    if (state_q == S_IDLE && cmd_valid_i) begin
      cmd_q <= cmd_i;
      bkt_q <= cmd_bucket_i;
    end
  end

  // Bucket memories: the valid bits are cleared by a sweep after reset and on a clear beat.
  always_ff @(posedge clk_i) begin
    if (bv_we) begin
      bvalid_mem_q[bv_waddr] <= bv_wval;
    end
  end

  always_ff @(posedge clk_i) begin
    bv_rd_q <= bvalid_mem_q[(state_q == S_IDLE) ? cmd_bucket_i : bkt_q];
    if (head_we) begin
      head_mem_q[bkt_q] <= SW'(count_q);
    end
    head_rd_q <= head_mem_q[cmd_bucket_i];
  end

  // Slot memories: one write port for inserts, one read port for the walk.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      key_mem_q[SW'(count_q)]  <= cmd_q.record_number;
      pay_mem_q[SW'(count_q)]  <= {cmd_q.tag_id, cmd_q.option_flags, ins_type};
      next_mem_q[SW'(count_q)] <= bv_rd_q ? {1'b0, head_q} : {1'b1, {SW{1'b0}}};
    end
    key_rd_q  <= key_mem_q[cur_d];
    next_rd_q <= next_mem_q[cur_d];
    pay_rd_q  <= pay_mem_q[cur_d];
  end

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= Capacity) else $error("entry count above capacity");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_ready_i) |=> rsp_valid_q) else $error("answer dropped");
  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_we |=> (count_q == $past(count_q) + 1'b1)) else $error("count not bumped");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_load |-> (!rsp_valid_q || rsp_ready_i)) else $error("answer overwritten");

endmodule

// File: sv/chained_hash_record_table.sv
// An insert or lookup reads its bucket, then walks the chain with one slot read per entry
// visited; a clear answers after a sweep over the bucket valid bits, and the unused code
// answers without a walk, with the walker idle.
// Throughput: one request at a time in the chain walker; a two-beat queue takes
// new requests while the walker is busy, and the answer waits in an output register.
// Reset: asynchronous, active low; entry count zero at once, chains emptied by a sweep over the bucket valid bits.
module chained_hash_record_table #(
  parameter int unsigned BUCKETS  = 1021,
  parameter int unsigned CAPACITY = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  chrt_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output chrt_pkg::rsp_t out_data_o
);

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic           cmd_valid, cmd_ready;
  chrt_pkg::req_t cmd;
  logic [BW-1:0]  cmd_bucket;

  chrt_front #(.Buckets(BUCKETS), .BW(BW)) u_front (
    .clk_i, .rst_ni,
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd),
    .cmd_bucket_o(cmd_bucket)
  );

  chrt_back #(.Buckets(BUCKETS), .Capacity(CAPACITY), .BW(BW), .SW(SW)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .cmd_bucket_i(cmd_bucket),
    .rsp_valid_o (out_valid_o),
    .rsp_ready_i (out_ready_i),
    .rsp_o       (out_data_o)
  );

endmodule
